### src/bte_pkg.sv
// ----------------------------------------------------------------------------
// bte_pkg
// Shared types and constants for the four-axis trajectory segment evaluator.
// ----------------------------------------------------------------------------
package bte_pkg;

    localparam int MAX_COEFFS = 8;
    localparam int AXES       = 4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_ZERODUR = 2'd2;
    localparam logic [1:0] ST_SAT     = 2'd3;

    typedef struct packed {
        logic        op;
        logic [1:0]  axis;
        logic [3:0]  point_index;
        logic [31:0] point_value;
        logic        last_point;
        logic [23:0] segment_duration;
        logic [23:0] eval_time;
    } cmd_t;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] heading;
        logic [1:0]  status;
    } res_t;

    // Pascal triangle, row a, column b
    localparam logic [6:0] BINOM [8][8] = '{
        '{7'd1, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0, 7'd0},
        '{7'd1, 7'd1,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0, 7'd0},
        '{7'd1, 7'd2,  7'd1,  7'd0,  7'd0,  7'd0,  7'd0, 7'd0},
        '{7'd1, 7'd3,  7'd3,  7'd1,  7'd0,  7'd0,  7'd0, 7'd0},
        '{7'd1, 7'd4,  7'd6,  7'd4,  7'd1,  7'd0,  7'd0, 7'd0},
        '{7'd1, 7'd5,  7'd10, 7'd10, 7'd5,  7'd1,  7'd0, 7'd0},
        '{7'd1, 7'd6,  7'd15, 7'd20, 7'd15, 7'd6,  7'd1, 7'd0},
        '{7'd1, 7'd7,  7'd21, 7'd35, 7'd35, 7'd21, 7'd7, 7'd1}
    };

endpackage

### src/bezier_trajectory_eval.sv
// ----------------------------------------------------------------------------
// bezier_trajectory_eval
// Four-axis Bezier segment store, power-basis conversion and Horner evaluation.
// ----------------------------------------------------------------------------
// A load item without last_point finishes from the idle state. One with last_point
//   converts n+1 points: per coefficient j it sums signed binomial terms, scales by
//   C(n,j), divides by the duration j times (restoring divide) and writes the row.
// Evaluate item: 8 Horner steps of read, multiply, sum and add, then a finish.
// One item at a time; busy is high until the result strobe; the receiver cannot
// stall. Reset clears the sequencer and all coefficient counts, not the memories.
// ----------------------------------------------------------------------------
module bezier_trajectory_eval
    import bte_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic done,
    output res_t res
);

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CV_RD    = 4'd1;   // read point i
    localparam logic [3:0] S_CV_ACC   = 4'd2;   // accumulate signed binomial term
    localparam logic [3:0] S_CV_SCALE = 4'd3;   // times C(n,j), or special case
    localparam logic [3:0] S_DIV_INIT = 4'd4;
    localparam logic [3:0] S_DIV      = 4'd5;   // 64 restoring steps
    localparam logic [3:0] S_DIV_END  = 4'd6;   // round already folded in, clamp
    localparam logic [3:0] S_CV_WR    = 4'd7;
    localparam logic [3:0] S_ZERO     = 4'd8;   // clear unused coefficients
    localparam logic [3:0] S_E_RD     = 4'd9;
    localparam logic [3:0] S_E_MUL    = 4'd10;
    localparam logic [3:0] S_E_SUM    = 4'd11;
    localparam logic [3:0] S_E_ADD    = 4'd12;
    localparam logic [3:0] S_E_FIN    = 4'd13;

    localparam logic signed [58:0] C48_MAX = 59'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [58:0] C48_MIN = -59'sh0_8000_0000_0000;
    localparam logic signed [47:0] I32_MAX = 48'sh7FFF_FFFF;
    localparam logic signed [47:0] I32_MIN = -48'sh8000_0000;

    // ------------------------------------------------------------------
    // Memories: points (axis, index) and coefficient rows (index, all axes)
    // ------------------------------------------------------------------
    logic [31:0]              pt_mem [32];
    logic [31:0]              pt_rd_reg;
    logic [AXES-1:0][47:0]    cf_mem [MAX_COEFFS];
    logic [AXES-1:0][47:0]    cf_rd_reg;

    logic        pt_we;
    logic [4:0]  pt_waddr;
    logic [4:0]  pt_raddr;
    logic        cf_we;
    logic [2:0]  cf_waddr;
    logic [47:0] cf_wdata;
    logic [2:0]  cf_raddr;

    // control
    logic [3:0]  state_reg, state_next;
    logic        done_reg, done_next;
    logic [3:0]  ccount_reg [AXES];
    logic [3:0]  ccount_next [AXES];

    // payload
    res_t        res_reg, res_next;
    logic [1:0]  ax_reg, ax_next;
    logic [3:0]  num_reg, num_next;
    logic [2:0]  n_reg, n_next;
    logic [23:0] dur_reg, dur_next;
    logic [23:0] t_reg, t_next;
    logic [1:0]  stat_reg, stat_next;
    logic        mid_reg, mid_next;     // two points, zero duration
    logic        err_reg, err_next;     // three or more points, zero duration
    logic [2:0]  j_reg, j_next;
    logic [2:0]  i_reg, i_next;
    logic [2:0]  k_reg, k_next;
    logic [3:0]  zj_reg, zj_next;
    logic signed [39:0] s_reg, s_next;
    logic signed [47:0] c_reg, c_next;
    logic [63:0] dq_reg, dq_next;
    logic [23:0] rem_reg, rem_next;
    logic [5:0]  dcnt_reg, dcnt_next;
    logic        dneg_reg, dneg_next;
    logic        sat_reg, sat_next;

    logic signed [47:0] r_reg [AXES];
    logic signed [47:0] r_next [AXES];
    logic [47:0]        mag_reg [AXES];
    logic [47:0]        mag_next [AXES];
    logic               neg_reg [AXES];
    logic               neg_next [AXES];
    logic [39:0]        ph_reg [AXES];
    logic [39:0]        ph_next [AXES];
    logic [55:0]        pl_reg [AXES];
    logic [55:0]        pl_next [AXES];
    logic signed [57:0] qs_reg [AXES];
    logic signed [57:0] qs_next [AXES];

    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            pt_mem[pt_waddr] <= cmd.point_value;
        end
        pt_rd_reg <= pt_mem[pt_raddr];
        if (cf_we)
        begin
            cf_mem[cf_waddr][ax_reg] <= cf_wdata;
        end
        cf_rd_reg <= cf_mem[cf_raddr];
    end

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    logic               accept;
    logic [6:0]         bm;
    logic signed [39:0] term;
    logic               sub;
    logic signed [47:0] s48;
    logic [47:0]        cmag;
    logic [24:0]        rem_sh;
    logic               ge;
    logic [63:0]        qlim;
    logic [63:0]        qc;
    logic [56:0]        qu;
    logic signed [58:0] v;
    logic signed [47:0] rc;
    logic [31:0]        pos [AXES];

    assign accept = start && (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        ax_next    = ax_reg;
        num_next   = num_reg;
        n_next     = n_reg;
        dur_next   = dur_reg;
        t_next     = t_reg;
        stat_next  = stat_reg;
        mid_next   = mid_reg;
        err_next   = err_reg;
        j_next     = j_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        zj_next    = zj_reg;
        s_next     = s_reg;
        c_next     = c_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        dcnt_next  = dcnt_reg;
        dneg_next  = dneg_reg;
        sat_next   = sat_reg;
        for (int a = 0; a < AXES; a++)
        begin
            ccount_next[a] = ccount_reg[a];
            r_next[a]      = r_reg[a];
            mag_next[a]    = mag_reg[a];
            neg_next[a]    = neg_reg[a];
            ph_next[a]     = ph_reg[a];
            pl_next[a]     = pl_reg[a];
            qs_next[a]     = qs_reg[a];
            pos[a]         = 32'd0;
        end

        pt_we    = 1'b0;
        pt_waddr = {cmd.axis, cmd.point_index[2:0]};
        pt_raddr = {ax_reg, i_reg};
        cf_we    = 1'b0;
        cf_waddr = j_reg;
        cf_wdata = c_reg;
        cf_raddr = j_reg;

        bm     = (mid_reg || err_reg) ? 7'd1 : BINOM[j_reg][i_reg];
        term   = $signed({33'd0, bm}) * $signed({{8{pt_rd_reg[31]}}, pt_rd_reg});
        sub    = (j_reg[0] ^ i_reg[0]) && !mid_reg;
        s48    = {{8{s_reg[39]}}, s_reg};
        cmag   = c_reg[47] ? 48'(-c_reg) : 48'(c_reg);
        rem_sh = {rem_reg, dq_reg[63]};
        ge     = rem_sh >= {1'b0, dur_reg};
        qlim   = dneg_reg ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
        qc     = (dq_reg > qlim) ? qlim : dq_reg;
        qu     = 57'd0;
        v      = 59'sd0;
        rc     = 48'sd0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next = '0;
                    if (cmd.op == OP_EVAL)
                    begin
                        t_next   = cmd.eval_time;
                        j_next   = 3'd7;
                        sat_next = 1'b0;
                        for (int a = 0; a < AXES; a++)
                        begin
                            r_next[a] = 48'sd0;
                        end
                        state_next = S_E_RD;
                    end
                    else
                    begin
                        pt_we     = !cmd.point_index[3];
                        stat_next = cmd.point_index[3] ? ST_DROPPED : ST_OK;
                        ax_next   = cmd.axis;
                        dur_next  = cmd.segment_duration;
                        num_next  = (cmd.point_index >= 4'd7) ? 4'd8
                                                             : cmd.point_index + 4'd1;
                        n_next    = (cmd.point_index >= 4'd7) ? 3'd7
                                                             : cmd.point_index[2:0];
                        if (cmd.last_point)
                        begin
                            mid_next = 1'b0;
                            err_next = 1'b0;
                            j_next   = 3'd0;
                            if (cmd.segment_duration == 24'd0 && cmd.point_index != 4'd0)
                            begin
                                if (cmd.point_index == 4'd1)
                                begin
                                    mid_next = 1'b1;
                                    j_next   = 3'd1;    // sum p0 + p1
                                end
                                else
                                begin
                                    err_next  = 1'b1;
                                    stat_next = ST_ZERODUR;
                                end
                            end
                            i_next     = 3'd0;
                            s_next     = 40'sd0;
                            state_next = S_CV_RD;
                        end
                        else
                        begin
                            res_next.status = cmd.point_index[3] ? ST_DROPPED : ST_OK;
                            done_next       = 1'b1;
                        end
                    end
                end
            end

            S_CV_RD:
            begin
                state_next = S_CV_ACC;
            end

            S_CV_ACC:
            begin
                s_next = sub ? s_reg - term : s_reg + term;
                if (i_reg == j_reg)
                begin
                    state_next = S_CV_SCALE;
                end
                else
                begin
                    i_next     = i_reg + 3'd1;
                    state_next = S_CV_RD;
                end
            end

            S_CV_SCALE:
            begin
                if (mid_reg)
                begin
                    c_next = s48 >>> 1;
                end
                else if (err_reg)
                begin
                    c_next = s48;
                end
                else
                begin
                    c_next = $signed({41'd0, BINOM[n_reg][j_reg]}) * s48;
                end
                k_next     = 3'd0;
                state_next = (mid_reg || err_reg || j_reg == 3'd0) ? S_CV_WR : S_DIV_INIT;
            end

            S_DIV_INIT:
            begin
                dneg_next  = c_reg[47];
                dq_next    = {cmag, 16'd0} + {41'd0, dur_reg[23:1]};
                rem_next   = 24'd0;
                dcnt_next  = 6'd0;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                rem_next  = ge ? 24'(rem_sh - {1'b0, dur_reg}) : rem_sh[23:0];
                dq_next   = {dq_reg[62:0], ge};
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == 6'd63)
                begin
                    state_next = S_DIV_END;
                end
            end

            S_DIV_END:
            begin
                c_next = dneg_reg ? $signed(-qc[47:0]) : $signed(qc[47:0]);
                k_next = k_reg + 3'd1;
                state_next = ({1'b0, k_reg} + 4'd1 == {1'b0, j_reg}) ? S_CV_WR : S_DIV_INIT;
            end

            S_CV_WR:
            begin
                cf_we = 1'b1;
                if (mid_reg || err_reg)
                begin
                    cf_waddr   = 3'd0;
                    zj_next    = 4'd1;
                    state_next = S_ZERO;
                end
                else if (j_reg == n_reg)
                begin
                    zj_next    = {1'b0, j_reg} + 4'd1;
                    state_next = S_ZERO;
                end
                else
                begin
                    j_next     = j_reg + 3'd1;
                    i_next     = 3'd0;
                    s_next     = 40'sd0;
                    state_next = S_CV_RD;
                end
            end

            S_ZERO:
            begin
                if (zj_reg[3])
                begin
                    ccount_next[ax_reg] = num_reg;
                    res_next.status     = stat_reg;
                    done_next           = 1'b1;
                    state_next          = S_IDLE;
                end
                else
                begin
                    cf_we    = 1'b1;
                    cf_waddr = zj_reg[2:0];
                    cf_wdata = 48'd0;
                    zj_next  = zj_reg + 4'd1;
                end
            end

            // Horner step: read row, magnitude, multiply, round, add and clamp
            S_E_RD:
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    neg_next[a] = r_reg[a][47];
                    mag_next[a] = r_reg[a][47] ? 48'(-r_reg[a]) : 48'(r_reg[a]);
                end
                state_next = S_E_MUL;
            end

            S_E_MUL:
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    ph_next[a] = mag_reg[a][47:32] * t_reg;
                    pl_next[a] = mag_reg[a][31:0] * t_reg;
                end
                state_next = S_E_SUM;
            end

            S_E_SUM:
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    qu = {1'b0, ph_reg[a], 16'd0} + 57'((pl_reg[a] + 56'd32768) >> 16);
                    qs_next[a] = neg_reg[a] ? -$signed({1'b0, qu}) : $signed({1'b0, qu});
                end
                state_next = S_E_ADD;
            end

            S_E_ADD:
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    v = {qs_reg[a][57], qs_reg[a]}
                        + {{11{cf_rd_reg[a][47]}}, cf_rd_reg[a]};
                    if (v > C48_MAX)
                    begin
                        rc = C48_MAX[47:0];
                    end
                    else if (v < C48_MIN)
                    begin
                        rc = C48_MIN[47:0];
                    end
                    else
                    begin
                        rc = v[47:0];
                    end
                    if ({1'b0, j_reg} < ccount_reg[a])
                    begin
                        r_next[a] = rc;
                        if (v > C48_MAX || v < C48_MIN)
                        begin
                            sat_next = 1'b1;
                        end
                    end
                end
                if (j_reg == 3'd0)
                begin
                    state_next = S_E_FIN;
                end
                else
                begin
                    j_next     = j_reg - 3'd1;
                    state_next = S_E_RD;
                end
            end

            S_E_FIN:
            begin
                stat_next = sat_reg ? ST_SAT : ST_OK;
                for (int a = 0; a < AXES; a++)
                begin
                    if (r_reg[a] > I32_MAX)
                    begin
                        pos[a]    = 32'h7FFF_FFFF;
                        stat_next = ST_SAT;
                    end
                    else if (r_reg[a] < I32_MIN)
                    begin
                        pos[a]    = 32'h8000_0000;
                        stat_next = ST_SAT;
                    end
                    else
                    begin
                        pos[a] = r_reg[a][31:0];
                    end
                end
                res_next.pos_x   = pos[0];
                res_next.pos_y   = pos[1];
                res_next.pos_z   = pos[2];
                res_next.heading = pos[3];
                res_next.status  = stat_next;
                done_next        = 1'b1;
                state_next       = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            for (int a = 0; a < AXES; a++)
            begin
                ccount_reg[a] <= 4'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            for (int a = 0; a < AXES; a++)
            begin
                ccount_reg[a] <= ccount_next[a];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        ax_reg   <= ax_next;
        num_reg  <= num_next;
        n_reg    <= n_next;
        dur_reg  <= dur_next;
        t_reg    <= t_next;
        stat_reg <= stat_next;
        mid_reg  <= mid_next;
        err_reg  <= err_next;
        j_reg    <= j_next;
        i_reg    <= i_next;
        k_reg    <= k_next;
        zj_reg   <= zj_next;
        s_reg    <= s_next;
        c_reg    <= c_next;
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        dcnt_reg <= dcnt_next;
        dneg_reg <= dneg_next;
        sat_reg  <= sat_next;
        for (int a = 0; a < AXES; a++)
        begin
            r_reg[a]   <= r_next[a];
            mag_reg[a] <= mag_next[a];
            neg_reg[a] <= neg_next[a];
            ph_reg[a]  <= ph_next[a];
            pl_reg[a]  <= pl_next[a];
            qs_reg[a]  <= qs_next[a];
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign res  = res_reg;

endmodule

### tb/bezier_trajectory_eval_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_trajectory_eval_tb
// Self-checking bench: loads random and corner-case Bezier segments on all
// axes, evaluates them at random and corner-case times and compares every result with an
// in-bench fixed-point model of conversion and Horner evaluation.
// ----------------------------------------------------------------------------
module bezier_trajectory_eval_tb
    import bte_pkg::*;
;

    localparam longint C48_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint C48_LO = -C48_HI - 1;
    localparam longint CYCLE_LIMIT = 64'd20_000_000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    cmd_t cmd;
    res_t res;

    bezier_trajectory_eval DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .res   (res)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---- segment model state ----
    logic signed [31:0] pts [AXES][MAX_COEFFS];
    longint             coefs [AXES][MAX_COEFFS];
    int                 n_coefs [AXES];

    res_t   pending_results [$];
    int     mismatch_count;
    int     sent_count;
    longint cycles;

    // table of directed items; dir_fixed marks rows with a hand-typed result
    cmd_t   dir_cmd [$];
    res_t   dir_res [$];
    bit     dir_fixed [$];

    function automatic longint binom(int a, int b);
        longint f [8] = '{1, 1, 2, 6, 24, 120, 720, 5040};
        return f[a] / (f[b] * f[a - b]);
    endfunction

    function automatic longint clip48(longint v, ref bit hit);
        if (v > C48_HI)
        begin
            hit = 1;
            return C48_HI;
        end
        if (v < C48_LO)
        begin
            hit = 1;
            return C48_LO;
        end
        return v;
    endfunction

    // c * 65536 / d, rounded half away from zero, clipped to 48 bits
    function automatic longint scale_by_duration(longint c, longint d);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (c < 0) ? 128'(-c) : 128'(c);
        q = ((mag << 16) + 128'(d / 2)) / 128'(d);
        if (c < 0)
        begin
            if (q > (128'd1 << 47))
                q = 128'd1 << 47;
            return -longint'(q);
        end
        if (q > 128'(C48_HI))
            q = 128'(C48_HI);
        return longint'(q);
    endfunction

    // r * t / 65536, rounded half away from zero (exact, 128-bit)
    function automatic longint time_product(longint r, longint t);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (r < 0) ? 128'(-r) : 128'(r);
        q = (mag * 128'(t) + 128'd32768) >> 16;
        return (r < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [1:0] build_segment(int ax, int num, longint dur);
        longint s;
        longint c;
        bit     dummy;
        int     n;
        n = num - 1;
        for (int k = 0; k < MAX_COEFFS; k++)
            coefs[ax][k] = 0;
        n_coefs[ax] = num;
        if (num >= 2 && dur == 0)
        begin
            if (num == 2)
            begin
                s = longint'(pts[ax][0]) + longint'(pts[ax][1]);
                coefs[ax][0] = (s >= 0) ? s / 2 : -((-s + 1) / 2);
                return ST_OK;
            end
            coefs[ax][0] = pts[ax][0];
            return ST_ZERODUR;
        end
        for (int j = 0; j <= n; j++)
        begin
            s = 0;
            for (int i = 0; i <= j; i++)
                s = ((j - i) % 2) ? s - binom(j, i) * pts[ax][i]
                                  : s + binom(j, i) * pts[ax][i];
            c = clip48(binom(n, j) * s, dummy);
            for (int k = 0; k < j; k++)
                c = scale_by_duration(c, dur);
            coefs[ax][j] = c;
        end
        return ST_OK;
    endfunction

    function automatic res_t predict_result(cmd_t c);
        res_t   r;
        bit     sat;
        longint acc;
        int     num;
        logic [1:0] st;
        r = '0;
        if (c.op == OP_LOAD)
        begin
            if (c.point_index < MAX_COEFFS)
                pts[c.axis][c.point_index] = c.point_value;
            else
                r.status = ST_DROPPED;
            if (c.last_point)
            begin
                num = (c.point_index + 1 < MAX_COEFFS) ? c.point_index + 1 : MAX_COEFFS;
                st = build_segment(c.axis, num, c.segment_duration);
                if (st != ST_OK)
                    r.status = st;
            end
            return r;
        end
        sat = 0;
        for (int a = 0; a < AXES; a++)
        begin
            acc = 0;
            for (int j = n_coefs[a] - 1; j >= 0; j--)
                acc = clip48(time_product(acc, c.eval_time) + coefs[a][j], sat);
            if (acc > 64'sd2147483647)
            begin
                acc = 64'sd2147483647;
                sat = 1;
            end
            if (acc < -64'sd2147483648)
            begin
                acc = -64'sd2147483648;
                sat = 1;
            end
            case (a)
                0: r.pos_x = acc[31:0];
                1: r.pos_y = acc[31:0];
                2: r.pos_z = acc[31:0];
                default: r.heading = acc[31:0];
            endcase
        end
        r.status = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("MISMATCH t=%0t %s got %h want %h", $realtime, what, got, want);
    endtask

    // ---- result checker: receiver cannot stall, so sample every done ----
    always @(posedge clk)
    begin
        res_t want;
        cycles <= cycles + 1;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", res.status, 0);
            else
            begin
                want = pending_results.pop_front();
                if (res.pos_x !== want.pos_x)
                    report_mismatch("pos_x", res.pos_x, want.pos_x);
                if (res.pos_y !== want.pos_y)
                    report_mismatch("pos_y", res.pos_y, want.pos_y);
                if (res.pos_z !== want.pos_z)
                    report_mismatch("pos_z", res.pos_z, want.pos_z);
                if (res.heading !== want.heading)
                    report_mismatch("heading", res.heading, want.heading);
                if (res.status !== want.status)
                    report_mismatch("status", res.status, want.status);
            end
        end
    end

    // timeout
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---- sender: burst/gap shaping ----
    int burst_left;

    task automatic send_item(cmd_t c, bit has_fixed, res_t fixed);
        res_t predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        burst_left--;
        cmd <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // accepted at this edge
        predicted = predict_result(c);
        sent_count++;
        if (has_fixed && predicted !== fixed)
            report_mismatch("model table", predicted.status, fixed.status);
        pending_results.push_back(predicted);
        start <= 1'b0;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic cmd_t load_cmd(int ax, int idx, logic [31:0] v, bit last,
                                      logic [23:0] dur);
        cmd_t c;
        c = '0;
        c.op = OP_LOAD;
        c.axis = ax[1:0];
        c.point_index = idx[3:0];
        c.point_value = v;
        c.last_point = last;
        c.segment_duration = dur;
        c.eval_time = 24'($urandom);
        return c;
    endfunction

    function automatic cmd_t eval_cmd(logic [23:0] t);
        cmd_t c;
        c = '0;
        c.op = OP_EVAL;
        c.eval_time = t;
        c.axis = 2'($urandom);
        c.point_index = 4'($urandom);
        c.point_value = $urandom;
        c.last_point = 1'($urandom);
        c.segment_duration = 24'($urandom);
        return c;
    endfunction

    task automatic add_row(cmd_t c, bit fixed, res_t r);
        dir_cmd.push_back(c);
        dir_fixed.push_back(fixed);
        dir_res.push_back(r);
    endtask

    function automatic res_t status_only(logic [1:0] s);
        res_t r;
        r = '0;
        r.status = s;
        return r;
    endfunction

    // random curve of random size (mostly small) on one axis, then evaluations
    task automatic random_segment();
        int          ax;
        int          num;
        logic [23:0] dur;
        logic [31:0] v;
        ax = $urandom_range(0, 3);
        num = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 5);
        case ($urandom_range(0, 9))
            0: dur = 24'd0;
            1: dur = 24'hFFFFFF;
            2: dur = 24'($urandom_range(1, 255));
            default: dur = 24'($urandom_range(24'h4000, 24'h40000));
        endcase
        for (int i = 0; i < num; i++)
        begin
            case ($urandom_range(0, 7))
                0: v = $urandom;
                1: v = ($urandom_range(0, 1)) ? 32'h7FFFFFFF : 32'h80000000;
                default: v = 32'($signed(16'($urandom)) * 16);
            endcase
            send_item(load_cmd(ax, i, v, i == num - 1, dur), 0, '0);
        end
        // an occasional dropped point beyond the store
        if ($urandom_range(0, 9) == 0)
            send_item(load_cmd(ax, $urandom_range(8, 15), $urandom, 0, 0), 0, '0);
        repeat ($urandom_range(1, 4))
            send_item(eval_cmd(($urandom_range(0, 3) == 0) ? 24'($urandom)
                               : 24'($urandom_range(0, dur))), 0, '0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cycles = 0;
        mismatch_count = 0;
        sent_count = 0;
        burst_left = 0;
        for (int a = 0; a < AXES; a++)
        begin
            n_coefs[a] = 0;
            for (int k = 0; k < MAX_COEFFS; k++)
            begin
                pts[a][k] = 0;
                coefs[a][k] = 0;
            end
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed table ----
        add_row(eval_cmd(24'hFFFFFF), 1, status_only(ST_OK));          // empty axes
        add_row(load_cmd(0, 0, 32'h7FFFFFFF, 1, 24'h010000), 1, status_only(ST_OK));
        add_row(load_cmd(1, 0, 32'h80000000, 0, 24'h0), 1, status_only(ST_OK));
        add_row(load_cmd(1, 1, 32'h80000001, 1, 24'h0), 1, status_only(ST_OK));
        add_row(eval_cmd(24'h0), 0, '0);                                // constant, midpoint
        add_row(load_cmd(2, 0, 32'h00010000, 0, 24'h0), 1, status_only(ST_OK));
        add_row(load_cmd(2, 1, 32'hFFFF0000, 0, 24'h0), 1, status_only(ST_OK));
        add_row(load_cmd(2, 2, 32'h00030000, 1, 24'h0), 1, status_only(ST_ZERODUR));
        add_row(eval_cmd(24'h123456), 0, '0);
        add_row(load_cmd(3, 15, 32'h12345678, 0, 24'h0), 1, status_only(ST_DROPPED));
        for (int i = 0; i < 8; i++)
            add_row(load_cmd(3, i, (i % 2) ? 32'h7FFFFFFF : 32'h80000000, 0, 0), 1,
                    status_only(ST_OK));
        // dropped last point converts eight points; duration at its smallest nonzero value
        add_row(load_cmd(3, 9, 32'h0, 1, 24'h000001), 1, status_only(ST_DROPPED));
        add_row(eval_cmd(24'hFFFFFF), 0, '0);
        add_row(eval_cmd(24'h000001), 0, '0);
        add_row(load_cmd(3, 10, 32'h0, 1, 24'h0), 1, status_only(ST_ZERODUR));
        add_row(load_cmd(0, 1, 32'h00020000, 1, 24'hFFFFFF), 1, status_only(ST_OK));
        add_row(eval_cmd(24'hFFFFFF), 0, '0);

        for (int r = 0; r < dir_cmd.size(); r++)
            send_item(dir_cmd[r], dir_fixed[r], dir_res[r]);

        // ---- random part ----
        while (sent_count < 2000)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(eval_cmd(24'($urandom)), 0, '0);
            else
                random_segment();
        end

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
src/bte_pkg.sv
src/bezier_trajectory_eval.sv
tb/bezier_trajectory_eval_tb.sv
